### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked every clock outside reset
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types, constants and lookup tables of the scale pitch quantizer.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int PITCH_W    = 13;
    localparam int FRAC_BITS  = 8;
    localparam int Q_W        = 5;
    localparam int RATE_W     = 18;
    localparam int ROOT_W     = 4;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 1;

    localparam int SEMIS      = 12;
    localparam int NUM_SCALES = 5;
    localparam int ROOT_MAX   = 11;
    localparam int Q_MIN      = -12;
    localparam int Q_MAX      = 12;
    localparam int RATE_MIN   = 32768;
    localparam int RATE_MAX   = 131072;

    // beyond two octaves the clamp decides the result alone
    localparam int N_SAT      = 2 * SEMIS;
    localparam int NMAG_W     = $clog2(N_SAT + 1);
    localparam int HALF       = (1 << FRAC_BITS) >> 1;

    typedef enum logic [2:0] {
        SCALE_CHROMATIC = 3'd0,
        SCALE_MAJOR     = 3'd1,
        SCALE_MINOR     = 3'd2,
        SCALE_PENTA     = 3'd3,
        SCALE_BLUES     = 3'd4
    } scale_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_SELECT = 1'b0,
        REG_ROOT_NOTE    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        scale_t              scale;
        logic [ROOT_W-1:0]   root;
    } spq_cfg_t;

    // nearest scale degree for each semitone, tie to the lower degree
    localparam logic [3:0] SNAP_TBL [NUM_SCALES][SEMIS] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
        '{4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd5, 4'd5, 4'd7, 4'd7, 4'd9, 4'd9,  4'd11},
        '{4'd0, 4'd0, 4'd2, 4'd3, 4'd3, 4'd5, 4'd5, 4'd7, 4'd8, 4'd8, 4'd10, 4'd10},
        '{4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd4, 4'd7, 4'd7, 4'd7, 4'd9, 4'd9,  4'd9},
        '{4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd5, 4'd6, 4'd7, 4'd7, 4'd10, 4'd10, 4'd10}
    };

    function automatic logic [3:0] snap_degree(scale_t s, logic [3:0] semi);
        return SNAP_TBL[s][semi];
    endfunction

    // round(65536 * 2^((idx - 12) / 12))
    function automatic logic [RATE_W-1:0] rate_lut(logic [4:0] idx);
        logic [RATE_W-1:0] r;
        case (idx)
            5'd0:    r = 18'd32768;
            5'd1:    r = 18'd34716;
            5'd2:    r = 18'd36781;
            5'd3:    r = 18'd38968;
            5'd4:    r = 18'd41285;
            5'd5:    r = 18'd43740;
            5'd6:    r = 18'd46341;
            5'd7:    r = 18'd49097;
            5'd8:    r = 18'd52016;
            5'd9:    r = 18'd55109;
            5'd10:   r = 18'd58386;
            5'd11:   r = 18'd61858;
            5'd12:   r = 18'd65536;
            5'd13:   r = 18'd69433;
            5'd14:   r = 18'd73562;
            5'd15:   r = 18'd77936;
            5'd16:   r = 18'd82570;
            5'd17:   r = 18'd87480;
            5'd18:   r = 18'd92682;
            5'd19:   r = 18'd98193;
            5'd20:   r = 18'd104032;
            5'd21:   r = 18'd110218;
            5'd22:   r = 18'd116772;
            5'd23:   r = 18'd123715;
            5'd24:   r = 18'd131072;
            default: r = 18'd65536;
        endcase
        return r;
    endfunction

endpackage

### rtl/spq_cfg.sv
// ----------------------------------------------------------------------------
// spq_cfg
// Configuration registers; out-of-range writes are clamped on the way in (scale codes use only cfg_data[2:0]).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_cfg
    import spq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output spq_cfg_t              cfg
);

    scale_t            scale_reg, scale_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    always_comb
    begin
        scale_next = scale_reg;
        root_next  = root_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SCALE_SELECT:
                begin
                    // unknown selector codes in cfg_data[2:0] fall back to blues; cfg_data[3] is ignored
                    if (cfg_data[2:0] > 3'(SCALE_BLUES))
                        scale_next = SCALE_BLUES;
                    else
                        scale_next = scale_t'(cfg_data[2:0]);
                end
                REG_ROOT_NOTE:
                begin
                    if (cfg_data > ROOT_W'(ROOT_MAX))
                        root_next = ROOT_W'(ROOT_MAX);
                    else
                        root_next = cfg_data;
                end
                default:
                begin
                    scale_next = scale_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_CHROMATIC;
            root_reg  <= '0;
        end
        else
        begin
            scale_reg <= scale_next;
            root_reg  <= root_next;
        end
    end

    assign cfg.scale = scale_reg;
    assign cfg.root  = root_reg;

    `SPQ_ASSERT(a_root_clamped, clk, rst_n, root_reg <= ROOT_W'(ROOT_MAX), "root note above 11")
    `SPQ_ASSERT_NEXT(a_root_write, clk, rst_n, cfg_valid && cfg_ready && cfg_index == REG_ROOT_NOTE && cfg_data <= ROOT_W'(ROOT_MAX), root_reg == $past(cfg_data), "root write lost")

endmodule

### rtl/spq_core.sv
// ----------------------------------------------------------------------------
// spq_core
// Rounding, octave split, scale snap, transpose, clamp and rate lookup.
// ----------------------------------------------------------------------------
module spq_core
    import spq_pkg::*;
(
    input  logic signed [PITCH_W-1:0] pitch,
    input  spq_cfg_t                  cfg,
    output logic signed [Q_W-1:0]     quantized,
    output logic        [RATE_W-1:0]  rate
);

    logic                     neg;
    logic [PITCH_W-1:0]       mag;
    logic [PITCH_W:0]         sum;
    logic [PITCH_W:0]         rnd;
    logic [NMAG_W-1:0]        mag_sat;
    logic signed [NMAG_W:0]   n;
    logic signed [6:0]        base;
    logic signed [6:0]        semi_w;
    logic [3:0]               deg;
    logic signed [6:0]        q_raw;
    logic signed [5:0]        q_ext;

    always_comb
    begin
        neg = pitch[PITCH_W-1];
        // magnitude of the most negative code still fits unsigned
        mag = neg ? PITCH_W'(~pitch + 1'b1) : PITCH_W'(pitch);
        sum = {1'b0, mag} + (PITCH_W+1)'(HALF);
        rnd = sum >> FRAC_BITS;
        if (rnd > (PITCH_W+1)'(N_SAT))
            mag_sat = NMAG_W'(N_SAT);
        else
            mag_sat = rnd[NMAG_W-1:0];
        n = neg ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});

        // floor split into octave base and semitone
        if (n >= (NMAG_W+1)'(N_SAT))
            base = 7'sd24;
        else if (n >= (NMAG_W+1)'(SEMIS))
            base = 7'sd12;
        else if (n >= 0)
            base = 7'sd0;
        else if (n >= -(NMAG_W+1)'(SEMIS))
            base = -7'sd12;
        else
            base = -7'sd24;

        semi_w = 7'(n) - base;
        deg    = snap_degree(cfg.scale, semi_w[3:0]);
        q_raw  = base + $signed({3'b000, deg}) + $signed({3'b000, cfg.root});

        if (q_raw < 7'(Q_MIN))
            quantized = Q_W'(Q_MIN);
        else if (q_raw > 7'(Q_MAX))
            quantized = Q_W'(Q_MAX);
        else
            quantized = q_raw[Q_W-1:0];

        q_ext = {quantized[Q_W-1], quantized};
        rate  = rate_lut(5'(q_ext + 6'sd12));
    end

endmodule

### rtl/scale_pitch_quantizer.sv
// ----------------------------------------------------------------------------
// scale_pitch_quantizer
// Snaps a fixed-point pitch offset to a musical scale and gives its rate.
// ----------------------------------------------------------------------------
// One pitch transfer is taken every clock while in_stall is low; each result
// passes the input register, the single pass of mapping logic and then the
// result register, from which it transfers when out_stall is low. With the
// output stalled the block still takes one more input into its input register
// before it stalls back.
// Scale and root are written on the cfg channel, which is always ready, and
// should only change while no item is in flight.
`include "assert_macros.svh"

module scale_pitch_quantizer
    import spq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [PITCH_W-1:0] pitch_offset,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [Q_W-1:0]     quantized_semitones,
    output logic        [RATE_W-1:0]  playback_rate
);

    spq_cfg_t                  cfg;
    logic                      s1_valid_reg, s1_valid_next;
    logic signed [PITCH_W-1:0] s1_pitch_reg, s1_pitch_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [Q_W-1:0]     q_reg, q_next;
    logic [RATE_W-1:0]         rate_reg, rate_next;
    logic signed [Q_W-1:0]     core_q;
    logic [RATE_W-1:0]         core_rate;
    logic                      s2_adv;
    logic                      s1_adv;

    assign cfg_ready = 1'b1;

    spq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spq_core u_core (
        .pitch     (s1_pitch_reg),
        .cfg       (cfg),
        .quantized (core_q),
        .rate      (core_rate)
    );

    // each stage moves when the one after it is empty or draining
    assign s2_adv   = !out_valid_reg || !out_stall;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_stall = !s1_adv;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_pitch_next  = s1_pitch_reg;
        out_valid_next = out_valid_reg;
        q_next         = q_reg;
        rate_next      = rate_reg;
        if (s1_adv)
        begin
            s1_valid_next = in_valid;
            if (in_valid)
                s1_pitch_next = pitch_offset;
        end
        if (s2_adv)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                q_next    = core_q;
                rate_next = core_rate;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pitch_reg <= s1_pitch_next;
        q_reg        <= q_next;
        rate_reg     <= rate_next;
    end

    assign out_valid           = out_valid_reg;
    assign quantized_semitones = q_reg;
    assign playback_rate       = rate_reg;

    `SPQ_ASSERT_NEXT(a_in_lands, clk, rst_n, in_valid && !in_stall, s1_valid_reg, "input transfer dropped")
    `SPQ_ASSERT_IMPL(a_stall_full, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg && out_stall, "stall with room left")
    `SPQ_ASSERT_IMPL(a_q_range, clk, rst_n, out_valid, quantized_semitones >= Q_W'(Q_MIN) && quantized_semitones <= Q_W'(Q_MAX), "quantized pitch out of range")
    `SPQ_ASSERT_IMPL(a_rate_match, clk, rst_n, out_valid, playback_rate == rate_lut(5'({quantized_semitones[Q_W-1], quantized_semitones} + 6'sd12)), "rate does not match pitch")

endmodule
